// File: rtl/vsl_pkg.sv
// shared constants, codes and helpers for the velocity setpoint limiter
`default_nettype none

package vsl_pkg;

    // register map
    typedef enum logic [2:0] {
        CFG_LOOKAHEAD  = 3'd0,
        CFG_MAX_HORIZ  = 3'd1,
        CFG_MAX_VERT   = 3'd2,
        CFG_MIN_ALT    = 3'd3,
        CFG_ORIGIN_UP  = 3'd4
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 21;

    localparam int LOOKAHEAD_W = 15;
    localparam int MAX_H_W     = 14;
    localparam int MAX_V_W     = 12;
    localparam int MIN_ALT_W   = 14;
    localparam int ORIGIN_W    = 21;

    localparam logic [LOOKAHEAD_W-1:0] LOOKAHEAD_RST = 15'd4000;
    localparam logic [MAX_H_W-1:0]     MAX_H_RST     = 14'd2500;
    localparam logic [MAX_V_W-1:0]     MAX_V_RST     = 12'd500;
    localparam logic [MIN_ALT_W-1:0]   MIN_ALT_RST   = 14'd50;
    localparam logic [ORIGIN_W-1:0]    ORIGIN_RST    = 21'd0;

    typedef enum logic [1:0] {
        MODE_VEL  = 2'd0,
        MODE_ALT  = 2'd1,
        MODE_LOOK = 2'd2
    } mode_t;

    // pipelined arithmetic units
    localparam int SQRT_IN_W   = 32;
    localparam int SPEED_W     = SQRT_IN_W / 2;
    localparam int SQRT_LAT    = SPEED_W;
    localparam int DIV1_NUM_W  = 30;
    localparam int DIV1_QUO_W  = 14;
    localparam int DIV2_NUM_W  = 31;
    localparam int DIV2_QUO_W  = 28;

    function automatic logic [23:0] sat_to_24(input logic [29:0] v);
        logic signed [29:0] sv;
        sv = $signed(v);
        if (sv > 30'sd8388607)
            return 24'h7fffff;
        else if (sv < -30'sd8388608)
            return 24'h800000;
        else
            return v[23:0];
    endfunction

    function automatic logic [27:0] sat_to_28(input logic [29:0] v);
        logic signed [29:0] sv;
        sv = $signed(v);
        if (sv > 30'sd134217727)
            return 28'h7ffffff;
        else if (sv < -30'sd134217728)
            return 28'h8000000;
        else
            return v[27:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/vsl_isqrt_pipe.sv
// pipelined integer square root, one result bit per stage
`default_nettype none

module vsl_isqrt_pipe #(
    parameter int IN_W = 32
) (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [IN_W-1:0]     x,
    output logic      [IN_W/2-1:0]   root
);

    localparam int OUT_W = IN_W / 2;
    localparam int RW    = OUT_W + 3;

    logic [RW-1:0]    rem_reg  [OUT_W];
    logic [OUT_W-1:0] root_reg [OUT_W];
    logic [IN_W-1:0]  x_reg    [OUT_W];

    for (genvar k = 0; k < OUT_W; k++) begin : g_stage
        logic [RW-1:0]    rem_in;
        logic [OUT_W-1:0] root_in;
        logic [IN_W-1:0]  x_in;
        logic [RW-1:0]    trial;
        logic [RW-1:0]    test;
        logic [RW-1:0]    rem_next;
        logic [OUT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = x;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign x_in    = x_reg[k-1];
        end

        always_comb
        begin
            trial = {rem_in[RW-3:0], x_in[IN_W-1-2*k -: 2]};
            test  = {1'b0, root_in, 2'b01};
            if (trial >= test)
            begin
                rem_next  = trial - test;
                root_next = {root_in[OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                root_next = {root_in[OUT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                x_reg[k]    <= x_in;
            end
        end
    end

    assign root = root_reg[OUT_W-1];

endmodule

`default_nettype wire

// File: rtl/vsl_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module vsl_div_pipe #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 16,
    parameter int QUO_W = 14
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    output logic      [QUO_W-1:0]  quo
);

    // caller keeps num below den shifted up by QUO_W bits
    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [NUM_W-1:0] num_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic [DEN_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (k == 0) begin : g_first
            assign rem_in = DEN_W'(num >> QUO_W);
            assign quo_in = '0;
            assign num_in = num;
            assign den_in = den;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign num_in = num_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        always_comb
        begin
            trial = {rem_in, num_in[QUO_W-1-k]};
            diff  = trial - {1'b0, den_in};
            if (trial >= {1'b0, den_in})
            begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_in[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_in[QUO_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
                num_reg[k] <= num_in;
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

`default_nettype wire

// File: rtl/velocity_setpoint_limiter_lookahead_core.sv
// top level of the velocity setpoint limiter with fixed-wing lookahead
`default_nettype none

// Takes one velocity request per cycle while in_stall is low and returns one
// limited setpoint per request, in order. Each request passes through a
// 16-stage square root of the horizontal speed squared, a 14-stage divider
// that rescales the horizontal velocity and a 28-stage divider that projects
// the lookahead target, plus nine registered stages around them. The whole
// pipeline holds while a finished setpoint waits on out_stall, so nothing is
// lost or repeated. The user must write configuration registers only while
// no request is in flight; the block itself does not enforce this.
module velocity_setpoint_limiter_lookahead_core (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [20:0]        cfg_data,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] cmd_east_vel,
    input  wire logic signed [15:0] cmd_north_vel,
    input  wire logic signed [15:0] cmd_up_vel,
    input  wire logic               fixed_wing_mode,
    input  wire logic               alt_hold,
    input  wire logic signed [20:0] target_altitude_cm,
    input  wire logic               position_known,
    input  wire logic signed [27:0] pos_north_cm,
    input  wire logic signed [27:0] pos_east_cm,
    input  wire logic signed [20:0] pos_down_cm,
    input  wire logic signed [15:0] yaw_rate_in,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      out_north_vel,
    output logic signed [15:0]      out_east_vel,
    output logic signed [15:0]      out_down_vel,
    output logic [1:0]              position_mode,
    output logic signed [27:0]      sp_north_cm,
    output logic signed [27:0]      sp_east_cm,
    output logic signed [23:0]      sp_down_cm,
    output logic signed [15:0]      yaw_rate_out,
    output logic                    yaw_rate_valid
);

    localparam int SQ_LAT = vsl_pkg::SQRT_LAT;
    localparam int D1_LAT = vsl_pkg::DIV1_QUO_W;
    localparam int D2_LAT = vsl_pkg::DIV2_QUO_W;
    localparam int SPD_W  = vsl_pkg::SPEED_W;

    typedef struct packed {
        logic [15:0] e;
        logic [15:0] n;
        logic [15:0] up;
        logic        fw;
        logic        hold;
        logic [20:0] tgt;
        logic        known;
        logic [27:0] pn;
        logic [27:0] pe;
        logic [20:0] pd;
        logic [15:0] yaw;
    } in_t;

    typedef struct packed {
        logic             fw;
        logic             hold;
        logic             known;
        logic [15:0]      yaw;
        logic [27:0]      pn;
        logic [27:0]      pe;
        logic [21:0]      base;
        logic [21:0]      local_tgt;
        logic [15:0]      upc;
        logic [15:0]      e;
        logic [15:0]      n;
        logic [15:0]      ea;
        logic [15:0]      na;
        logic [29:0]      emh;
        logic [29:0]      nmh;
        logic             scaled;
        logic             fast_u;
        logic [SPD_W-1:0] root;
    } side_a_t;

    typedef struct packed {
        logic             fw;
        logic             hold;
        logic             known;
        logic [15:0]      yaw;
        logic [27:0]      pn;
        logic [27:0]      pe;
        logic [21:0]      base;
        logic [21:0]      local_tgt;
        logic [15:0]      upc;
        logic [15:0]      e_out;
        logic [15:0]      n_out;
        logic             neg_e;
        logic             neg_n;
        logic             neg_up;
        logic [SPD_W-1:0] speed;
        logic             fast;
        logic [15:0]      mag_e;
        logic [15:0]      mag_n;
        logic [15:0]      mag_up;
    } side_b_t;

    // configuration registers
    logic [14:0] lookahead_reg;
    logic [13:0] max_h_reg;
    logic [11:0] max_v_reg;
    logic [13:0] min_alt_reg;
    logic [20:0] origin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookahead_reg <= vsl_pkg::LOOKAHEAD_RST;
            max_h_reg     <= vsl_pkg::MAX_H_RST;
            max_v_reg     <= vsl_pkg::MAX_V_RST;
            min_alt_reg   <= vsl_pkg::MIN_ALT_RST;
            origin_reg    <= vsl_pkg::ORIGIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vsl_pkg::CFG_LOOKAHEAD: lookahead_reg <= cfg_data[14:0];
                vsl_pkg::CFG_MAX_HORIZ: max_h_reg     <= cfg_data[13:0];
                vsl_pkg::CFG_MAX_VERT:  max_v_reg     <= cfg_data[11:0];
                vsl_pkg::CFG_MIN_ALT:   min_alt_reg   <= cfg_data[13:0];
                vsl_pkg::CFG_ORIGIN_UP: origin_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: everything moves unless a finished result is held
    logic adv;
    logic v9_reg;

    assign adv      = !(v9_reg && out_stall);
    assign in_stall = !adv;

    // valid bits
    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic [SQ_LAT-1:0] v_sq_reg;
    logic [D1_LAT-1:0] v_d1_reg;
    logic [D2_LAT-1:0] v_d2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v_sq_reg <= '0;
            v4_reg   <= 1'b0;
            v_d1_reg <= '0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v_d2_reg <= '0;
            v8_reg   <= 1'b0;
            v9_reg   <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v_sq_reg <= {v_sq_reg[SQ_LAT-2:0], v3_reg};
            v4_reg   <= v_sq_reg[SQ_LAT-1];
            v_d1_reg <= {v_d1_reg[D1_LAT-2:0], v4_reg};
            v5_reg   <= v_d1_reg[D1_LAT-1];
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            v_d2_reg <= {v_d2_reg[D2_LAT-2:0], v7_reg};
            v8_reg   <= v_d2_reg[D2_LAT-1];
            v9_reg   <= v8_reg;
        end
    end

    // stage 1: input register
    in_t in1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in1_reg.e     <= cmd_east_vel;
            in1_reg.n     <= cmd_north_vel;
            in1_reg.up    <= cmd_up_vel;
            in1_reg.fw    <= fixed_wing_mode;
            in1_reg.hold  <= alt_hold;
            in1_reg.tgt   <= target_altitude_cm;
            in1_reg.known <= position_known;
            in1_reg.pn    <= pos_north_cm;
            in1_reg.pe    <= pos_east_cm;
            in1_reg.pd    <= pos_down_cm;
            in1_reg.yaw   <= yaw_rate_in;
        end
    end

    // stage 2: squares, products with the limit, vertical clamp, base altitude
    side_a_t           sa2_next, sa2_reg;
    logic [31:0]       esq2_next, nsq2_next, esq2_reg, nsq2_reg;
    logic [27:0]       maxh2_next, maxh2_reg;
    logic signed [16:0] up17, mv17, upc17;
    logic signed [21:0] local22, cur22;

    always_comb
    begin
        esq2_next  = 32'($signed(in1_reg.e) * $signed(in1_reg.e));
        nsq2_next  = 32'($signed(in1_reg.n) * $signed(in1_reg.n));
        maxh2_next = 28'(max_h_reg) * 28'(max_h_reg);

        up17 = 17'($signed(in1_reg.up));
        mv17 = $signed({5'b0, max_v_reg});
        if (up17 > mv17)
            upc17 = mv17;
        else if (up17 < -mv17)
            upc17 = -mv17;
        else
            upc17 = up17;

        local22 = 22'($signed(in1_reg.tgt)) - 22'($signed(origin_reg));
        cur22   = -22'($signed(in1_reg.pd));

        sa2_next.fw        = in1_reg.fw;
        sa2_next.hold      = in1_reg.hold;
        sa2_next.known     = in1_reg.known;
        sa2_next.yaw       = in1_reg.yaw;
        sa2_next.pn        = in1_reg.pn;
        sa2_next.pe        = in1_reg.pe;
        sa2_next.local_tgt = local22;
        // climbing commands never aim below the current height
        sa2_next.base      = (upc17 > 17'sd0 && cur22 > local22) ? cur22 : local22;
        sa2_next.upc       = upc17[15:0];
        sa2_next.e         = in1_reg.e;
        sa2_next.n         = in1_reg.n;
        sa2_next.ea        = in1_reg.e[15] ? 16'(-in1_reg.e) : in1_reg.e;
        sa2_next.na        = in1_reg.n[15] ? 16'(-in1_reg.n) : in1_reg.n;
        sa2_next.emh       = 30'(sa2_next.ea) * 30'(max_h_reg);
        sa2_next.nmh       = 30'(sa2_next.na) * 30'(max_h_reg);
        sa2_next.scaled    = 1'b0;
        sa2_next.fast_u    = 1'b0;
        sa2_next.root      = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa2_reg   <= sa2_next;
            esq2_reg  <= esq2_next;
            nsq2_reg  <= nsq2_next;
            maxh2_reg <= maxh2_next;
        end
    end

    // stage 3: horizontal speed squared and the scaling decision
    side_a_t     sa3_next, sa3_reg;
    logic [31:0] h2_next, h2_reg;

    always_comb
    begin
        h2_next         = esq2_reg + nsq2_reg;
        sa3_next        = sa2_reg;
        sa3_next.scaled = h2_next > {4'b0, maxh2_reg};
        sa3_next.fast_u = h2_next > 32'd100;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa3_reg <= sa3_next;
            h2_reg  <= h2_next;
        end
    end

    // square root, sideband delayed alongside
    logic [SPD_W-1:0] root;
    side_a_t          sa_sq_reg [SQ_LAT];

    vsl_isqrt_pipe #(
        .IN_W (vsl_pkg::SQRT_IN_W)
    ) u_isqrt (
        .clk  (clk),
        .en   (adv),
        .x    (h2_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_sq_reg[0] <= sa3_reg;
            for (int i = 1; i < SQ_LAT; i++)
                sa_sq_reg[i] <= sa_sq_reg[i-1];
        end
    end

    // stage 4: rounded dividends for rescaling
    side_a_t     sa4_next, sa4_reg;
    logic [29:0] nume4_reg, numn4_reg;

    always_comb
    begin
        sa4_next      = sa_sq_reg[SQ_LAT-1];
        sa4_next.root = root;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa4_reg   <= sa4_next;
            nume4_reg <= sa4_next.emh + 30'(root >> 1);
            numn4_reg <= sa4_next.nmh + 30'(root >> 1);
        end
    end

    logic [D1_LAT-1:0] qe1, qn1;
    side_a_t           sa_d1_reg [D1_LAT];

    vsl_div_pipe #(
        .NUM_W (vsl_pkg::DIV1_NUM_W),
        .DEN_W (SPD_W),
        .QUO_W (D1_LAT)
    ) u_div_rescale_e (
        .clk (clk),
        .en  (adv),
        .num (nume4_reg),
        .den (sa4_reg.root),
        .quo (qe1)
    );

    vsl_div_pipe #(
        .NUM_W (vsl_pkg::DIV1_NUM_W),
        .DEN_W (SPD_W),
        .QUO_W (D1_LAT)
    ) u_div_rescale_n (
        .clk (clk),
        .en  (adv),
        .num (numn4_reg),
        .den (sa4_reg.root),
        .quo (qn1)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_d1_reg[0] <= sa4_reg;
            for (int i = 1; i < D1_LAT; i++)
                sa_d1_reg[i] <= sa_d1_reg[i-1];
        end
    end

    // stage 5: limited horizontal velocity, speed and magnitudes
    side_b_t     sb5_next, sb5_reg;
    side_a_t     sa5;
    logic [15:0] qe16, qn16;

    always_comb
    begin
        sa5  = sa_d1_reg[D1_LAT-1];
        qe16 = 16'(qe1);
        qn16 = 16'(qn1);

        sb5_next.fw        = sa5.fw;
        sb5_next.hold      = sa5.hold;
        sb5_next.known     = sa5.known;
        sb5_next.yaw       = sa5.yaw;
        sb5_next.pn        = sa5.pn;
        sb5_next.pe        = sa5.pe;
        sb5_next.base      = sa5.base;
        sb5_next.local_tgt = sa5.local_tgt;
        sb5_next.upc       = sa5.upc;
        sb5_next.neg_e     = sa5.e[15];
        sb5_next.neg_n     = sa5.n[15];
        sb5_next.neg_up    = sa5.upc[15];
        sb5_next.mag_up    = sa5.upc[15] ? 16'(-sa5.upc) : sa5.upc;
        if (sa5.scaled)
        begin
            sb5_next.e_out = sa5.e[15] ? 16'(-qe16) : qe16;
            sb5_next.n_out = sa5.n[15] ? 16'(-qn16) : qn16;
            sb5_next.mag_e = qe16;
            sb5_next.mag_n = qn16;
            sb5_next.speed = SPD_W'(max_h_reg);
            sb5_next.fast  = max_h_reg > 14'd10;
        end
        else
        begin
            sb5_next.e_out = sa5.e;
            sb5_next.n_out = sa5.n;
            sb5_next.mag_e = sa5.ea;
            sb5_next.mag_n = sa5.na;
            sb5_next.speed = sa5.root;
            sb5_next.fast  = sa5.fast_u;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            sb5_reg <= sb5_next;
    end

    // stage 6: lookahead products
    side_b_t     sb6_reg;
    logic [30:0] prod_e6_reg, prod_n6_reg, prod_up6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb6_reg      <= sb5_reg;
            prod_e6_reg  <= 31'(sb5_reg.mag_e) * 31'(lookahead_reg);
            prod_n6_reg  <= 31'(sb5_reg.mag_n) * 31'(lookahead_reg);
            prod_up6_reg <= 31'(sb5_reg.mag_up) * 31'(lookahead_reg);
        end
    end

    // stage 7: rounded dividends for the lookahead
    side_b_t     sb7_reg;
    logic [30:0] num_e7_reg, num_n7_reg, num_up7_reg;
    logic [30:0] half_speed;

    assign half_speed = 31'(sb6_reg.speed >> 1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb7_reg     <= sb6_reg;
            num_e7_reg  <= prod_e6_reg + half_speed;
            num_n7_reg  <= prod_n6_reg + half_speed;
            num_up7_reg <= prod_up6_reg + half_speed;
        end
    end

    logic [D2_LAT-1:0] qe2, qn2, qup2;
    side_b_t           sb_d2_reg [D2_LAT];

    vsl_div_pipe #(
        .NUM_W (vsl_pkg::DIV2_NUM_W),
        .DEN_W (SPD_W),
        .QUO_W (D2_LAT)
    ) u_div_look_e (
        .clk (clk),
        .en  (adv),
        .num (num_e7_reg),
        .den (sb7_reg.speed),
        .quo (qe2)
    );

    vsl_div_pipe #(
        .NUM_W (vsl_pkg::DIV2_NUM_W),
        .DEN_W (SPD_W),
        .QUO_W (D2_LAT)
    ) u_div_look_n (
        .clk (clk),
        .en  (adv),
        .num (num_n7_reg),
        .den (sb7_reg.speed),
        .quo (qn2)
    );

    vsl_div_pipe #(
        .NUM_W (vsl_pkg::DIV2_NUM_W),
        .DEN_W (SPD_W),
        .QUO_W (D2_LAT)
    ) u_div_look_up (
        .clk (clk),
        .en  (adv),
        .num (num_up7_reg),
        .den (sb7_reg.speed),
        .quo (qup2)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_d2_reg[0] <= sb7_reg;
            for (int i = 1; i < D2_LAT; i++)
                sb_d2_reg[i] <= sb_d2_reg[i-1];
        end
    end

    // stage 8: signed offsets added to position and base altitude
    side_b_t     sb8_reg, sb8_in;
    logic [29:0] off_e, off_n, off_up;
    logic [29:0] spe8_reg, spn8_reg, proj8_reg;

    always_comb
    begin
        sb8_in = sb_d2_reg[D2_LAT-1];
        off_e  = sb8_in.neg_e  ? -(30'(qe2))  : 30'(qe2);
        off_n  = sb8_in.neg_n  ? -(30'(qn2))  : 30'(qn2);
        off_up = sb8_in.neg_up ? -(30'(qup2)) : 30'(qup2);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb8_reg   <= sb8_in;
            spe8_reg  <= {{2{sb8_in.pe[27]}}, sb8_in.pe} + off_e;
            spn8_reg  <= {{2{sb8_in.pn[27]}}, sb8_in.pn} + off_n;
            proj8_reg <= {{8{sb8_in.base[21]}}, sb8_in.base} + off_up;
        end
    end

    // stage 9: mode selection, altitude floor, saturation, output register
    logic [29:0]     minalt30, local30, proj_f, alt_f;
    logic            use_fw, use_mc;
    vsl_pkg::mode_t  mode_next, mode_reg;
    logic [27:0]     spn_next, spe_next;
    logic [23:0]     spd_next;
    logic [15:0]     north_reg, east_reg, down_reg, yaw_reg;
    logic [27:0]     spn_reg, spe_reg;
    logic [23:0]     spd_reg;
    logic            yaw_valid_reg;

    always_comb
    begin
        minalt30 = {16'b0, min_alt_reg};
        local30  = {{8{sb8_reg.local_tgt[21]}}, sb8_reg.local_tgt};
        proj_f   = ($signed(proj8_reg) < $signed(minalt30)) ? minalt30 : proj8_reg;
        alt_f    = ($signed(local30) < $signed(minalt30)) ? minalt30 : local30;

        use_fw = sb8_reg.fw && sb8_reg.hold && sb8_reg.known && sb8_reg.fast;
        use_mc = !sb8_reg.fw && sb8_reg.hold && sb8_reg.known
                 && $signed(sb8_reg.upc) < 16'sd5 && $signed(sb8_reg.upc) > -16'sd5;

        if (use_fw)
        begin
            mode_next = vsl_pkg::MODE_LOOK;
            spn_next  = vsl_pkg::sat_to_28(spn8_reg);
            spe_next  = vsl_pkg::sat_to_28(spe8_reg);
            spd_next  = vsl_pkg::sat_to_24(-proj_f);
        end
        else if (use_mc)
        begin
            mode_next = vsl_pkg::MODE_ALT;
            spn_next  = '0;
            spe_next  = '0;
            spd_next  = vsl_pkg::sat_to_24(-alt_f);
        end
        else
        begin
            mode_next = vsl_pkg::MODE_VEL;
            spn_next  = '0;
            spe_next  = '0;
            spd_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            north_reg     <= sb8_reg.n_out;
            east_reg      <= sb8_reg.e_out;
            down_reg      <= -sb8_reg.upc;
            mode_reg      <= mode_next;
            spn_reg       <= spn_next;
            spe_reg       <= spe_next;
            spd_reg       <= spd_next;
            yaw_reg       <= sb8_reg.fw ? 16'd0 : sb8_reg.yaw;
            yaw_valid_reg <= !sb8_reg.fw;
        end
    end

    assign out_valid      = v9_reg;
    assign out_north_vel  = north_reg;
    assign out_east_vel   = east_reg;
    assign out_down_vel   = down_reg;
    assign position_mode  = mode_reg;
    assign sp_north_cm    = spn_reg;
    assign sp_east_cm     = spe_reg;
    assign sp_down_cm     = spd_reg;
    assign yaw_rate_out   = yaw_reg;
    assign yaw_rate_valid = yaw_valid_reg;

    // lookahead targets only come from fixed-wing requests
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && position_mode == vsl_pkg::MODE_LOOK) |-> !yaw_rate_valid)
        else $error("lookahead mode on a multicopter request");

    // velocity-only results carry no position target
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && position_mode == vsl_pkg::MODE_VEL)
            |-> (sp_north_cm == 28'sd0 && sp_east_cm == 28'sd0 && sp_down_cm == 24'sd0))
        else $error("position target set in velocity-only mode");

    // altitude hold only sets the down target
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && position_mode == vsl_pkg::MODE_ALT)
            |-> (sp_north_cm == 28'sd0 && sp_east_cm == 28'sd0 && yaw_rate_valid))
        else $error("altitude hold result carries horizontal target");

    // vertical velocity stays inside the clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed({{2{out_down_vel[15]}}, out_down_vel}) <=
                       $signed({6'b0, max_v_reg}) &&
                       $signed({{2{out_down_vel[15]}}, out_down_vel}) >=
                       -$signed({6'b0, max_v_reg})))
        else $error("down velocity outside the vertical clamp");

endmodule

`default_nettype wire
